>>> src/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Holds the list sizing, the operation and status codes, and the cell command struct.
// No dependencies.
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int CNTF_W   = 7;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_DATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_FLD_W  = VAL_W + STAT_W + CNTF_W + 1;
    localparam int M_DATA_W = ((M_FLD_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_DEL
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CMP_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } t_cmd;

endpackage

>>> src/ple_cell.sv
// One list cell: holds the element at its own index.
// Takes the left neighbour's element on an insert before it, the right one on a delete.
// Depends on ple_pkg.
module ple_cell import ple_pkg::*; (
    input  logic             i_clk,
    input  logic [CMP_W-1:0] i_idx,
    input  t_cmd             i_cmd,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    output logic [VAL_W-1:0] o_value,
    output logic [VAL_W-1:0] o_rd
);

    logic [VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_INS: begin
                if (i_idx > i_cmd.pos) begin
                    r_value <= i_left;
                end else if (i_idx == i_cmd.pos) begin
                    r_value <= i_cmd.value;
                end
            end
            OP_DEL: begin
                if (i_idx >= i_cmd.pos) begin
                    r_value <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_value = r_value;
    assign o_rd    = (i_idx == i_cmd.pos) ? r_value : '0;

endmodule

>>> src/positional_list_engine.sv
// Positional list engine: ordered list of signed values with insert, delete and read by position.
// An item's result is registered at acceptance; one item per cycle unless the output stalls.
// Inserts and deletes move the cells from the position upward by one place at once.
// Reset (synchronous, active low) empties the list and clears the output valid flag.
// Cell contents are not reset; entries at or above the count are never read.
// Depends on ple_pkg and ple_cell.
module positional_list_engine import ple_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // position[6:0], value[38:7], zero pad
    input  logic [KIND_W-1:0]   i_s_tuser,  // kind[1:0]
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata   // read_value[31:0], status[33:32],
                                            // count[40:34], empty_res[41], zero pad
);

    t_kind            w_kind;
    logic [POS_W-1:0] w_pos;
    logic [VAL_W-1:0] w_val;
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_cnt_x;
    logic             w_acc;
    t_cmd             w_cmd;
    logic [VAL_W-1:0] w_rd;

    logic [VAL_W-1:0] w_cell_val [CAPACITY];
    logic [VAL_W-1:0] w_cell_rd  [CAPACITY];

    logic [CNT_W-1:0] r_count,  n_count;
    logic             r_mvalid;
    logic [VAL_W-1:0] r_rv,     n_rv;
    t_status          r_status, n_status;
    logic [CNT_W-1:0] r_ocount;
    t_op              n_op;

    assign w_kind  = t_kind'(i_s_tuser);
    assign w_pos   = i_s_tdata[POS_W-1:0];
    assign w_val   = i_s_tdata[POS_W+VAL_W-1:POS_W];
    assign w_pos_x = CMP_W'(w_pos);
    assign w_cnt_x = CMP_W'(r_count);

    assign o_s_tready = !r_mvalid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_count  = r_count;
        n_rv     = '0;
        n_status = ST_OK;
        n_op     = OP_NONE;
        case (w_kind)
            KIND_INSERT: begin
                if (w_pos_x > w_cnt_x) begin
                    n_status = ST_BAD_POS;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_op    = OP_INS;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            KIND_DELETE: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_op    = OP_DEL;
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            KIND_READ: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_status = ST_BAD_POS;
                    n_rv     = '1;
                end else begin
                    n_rv = w_rd;
                end
            end
            default: begin
                n_status = ST_BAD_POS;
            end
        endcase
    end

    always_comb begin
        w_cmd.op    = w_acc ? n_op : OP_NONE;
        w_cmd.pos   = w_pos_x;
        w_cmd.value = w_val;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_val;
        end else begin : g_mid_l
            assign w_left = w_cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_val[g+1];
        end
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (CMP_W'(g)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell_val[g]),
            .o_rd    (w_cell_rd[g])
        );
    end

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count  <= n_count;
                r_mvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rv     <= n_rv;
            r_status <= n_status;
            r_ocount <= n_count;
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = {(M_DATA_W - M_FLD_W)'(0), (r_ocount == '0), CNTF_W'(r_ocount),
                         r_status, r_rv};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_m_tvalid)
        else $error("accepted item produced no result");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd.op == OP_INS) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("insert did not grow the list");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[M_FLD_W-1] == (r_ocount == '0)))
        else $error("empty flag disagrees with count");

endmodule
